// ===== rtl/modbus_rtu_slave_frame_handler_top_macros.svh =====
// Assertion macros for the frame handler reply sequencer (mbrtu_back)
`ifndef MODBUS_RTU_SLAVE_FRAME_HANDLER_TOP_MACROS_SVH
`define MODBUS_RTU_SLAVE_FRAME_HANDLER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MBRTU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MBRTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mbrtu_pkg.sv =====
// Package: constants, command type and CRC helper for the Modbus RTU frame handler
package mbrtu_pkg;

  localparam int BUFFER_DEPTH = 24;
  localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int FRAME_LEN    = 8;
  localparam int FIDX_W       = $clog2(FRAME_LEN);
  localparam int CRC_LEN      = 6;
  localparam int CMD_FIFO_DEPTH = 2;

  localparam logic [7:0]  FC_READ     = 8'h03;
  localparam logic [7:0]  FC_WRITE    = 8'h06;
  localparam logic [7:0]  REG_ALARM   = 8'h04;
  localparam logic [7:0]  READ_COUNT  = 8'h01;
  localparam logic [7:0]  BYTE_COUNT  = 8'h03;
  localparam logic [7:0]  SENSOR_TYPE = 8'h02;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  localparam logic [7:0]  ADDR_RST = 8'h01;
  localparam logic [15:0] GAP_RST  = 16'd3686;

  // configuration register index (paddr[2])
  localparam logic REG_IDX_ADDR = 1'b0;
  localparam logic REG_IDX_GAP  = 1'b1;

  typedef struct packed {
    logic        is_alarm;
    logic        alarm_on;
    logic [15:0] pressure;
  } mbrtu_cmd_t;

  function automatic logic [15:0] crc16_upd(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/mbrtu_if.sv =====
// Valid/ready channel interfaces for the request and result streams
interface mbrtu_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  rx_byte;
  logic [15:0] pressure;

  modport source (output valid, action, rx_byte, pressure, input ready);
  modport sink   (input valid, action, rx_byte, pressure, output ready);
endinterface

interface mbrtu_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic       last;
  logic       alarm_on;

  modport source (output valid, kind, tx_byte, last, alarm_on, input ready);
  modport sink   (input valid, kind, tx_byte, last, alarm_on, output ready);
endinterface

// ===== rtl/mbrtu_front.sv =====
// Front end: frame collection, gap timing and request decode
module mbrtu_front import mbrtu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  mbrtu_in_if.sink         in_ch,
  input  logic [7:0]       dev_addr,
  input  logic [15:0]      gap_ticks,
  input  logic             cmd_full,
  output logic             cmd_push,
  output mbrtu_cmd_t       cmd_data
);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic [15:0]      idle_cnt_r, idle_cnt_nxt;
  logic             idle_run_r, idle_run_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       frm_r [FRAME_LEN];
  logic             frm_we;
  logic [15:0]      cnt_inc;
  logic             accept;
  logic             frame_end;
  logic             frame_ok;
  logic             is_read;
  logic             is_write;

  assign in_ch.ready = !cmd_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign cnt_inc   = (idle_cnt_r == 16'hFFFF) ? idle_cnt_r : idle_cnt_r + 16'd1;
  assign frame_end = accept && in_ch.action && idle_run_r && (cnt_inc >= gap_ticks) &&
                     (len_r != '0);

  assign frame_ok = !ovf_r && (len_r == LEN_W'(FRAME_LEN)) && (frm_r[0] == dev_addr) &&
                    (frm_r[6] == crc_r[7:0]) && (frm_r[7] == crc_r[15:8]);
  assign is_read  = (frm_r[1] == FC_READ) && (frm_r[2] == 8'h00) && (frm_r[3] == 8'h00) &&
                    (frm_r[4] == 8'h00) && (frm_r[5] == READ_COUNT);
  assign is_write = (frm_r[1] == FC_WRITE) && (frm_r[2] == 8'h00) &&
                    (frm_r[3] == REG_ALARM) && (frm_r[4] == 8'h00);

  assign cmd_push          = frame_end && frame_ok && (is_read || is_write);
  assign cmd_data.is_alarm = !is_read;
  assign cmd_data.alarm_on = !is_read && (frm_r[5] != 8'h00);
  assign cmd_data.pressure = in_ch.pressure;

  always_comb begin
    len_nxt      = len_r;
    ovf_nxt      = ovf_r;
    idle_cnt_nxt = idle_cnt_r;
    idle_run_nxt = idle_run_r;
    crc_nxt      = crc_r;
    frm_we       = 1'b0;
    if (accept && !in_ch.action) begin
      if (len_r < LEN_W'(BUFFER_DEPTH)) begin
        len_nxt = len_r + LEN_W'(1);
        frm_we  = (len_r < LEN_W'(FRAME_LEN));
        // running CRC over the header bytes only
        if (len_r < LEN_W'(CRC_LEN)) begin
          crc_nxt = crc16_upd((len_r == '0) ? CRC_INIT : crc_r, in_ch.rx_byte);
        end
      end else begin
        ovf_nxt = 1'b1;
      end
      idle_cnt_nxt = '0;
      idle_run_nxt = 1'b1;
    end else if (accept && idle_run_r) begin
      if (frame_end) begin
        idle_run_nxt = 1'b0;
        idle_cnt_nxt = '0;
        len_nxt      = '0;
        ovf_nxt      = 1'b0;
      end else begin
        idle_cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      ovf_r      <= 1'b0;
      idle_cnt_r <= '0;
      idle_run_r <= 1'b0;
    end else begin
      len_r      <= len_nxt;
      ovf_r      <= ovf_nxt;
      idle_cnt_r <= idle_cnt_nxt;
      idle_run_r <= idle_run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (frm_we) begin
      frm_r[len_r[FIDX_W-1:0]] <= in_ch.rx_byte;
    end
  end

endmodule

// ===== rtl/mbrtu_cmd_fifo.sv =====
// Small command queue between request decode and reply generation
module mbrtu_cmd_fifo import mbrtu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  mbrtu_cmd_t push_data,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output mbrtu_cmd_t head
);

  localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
  localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

  mbrtu_cmd_t       mem_r [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(CMD_FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/mbrtu_back.sv =====
// Back end: reply byte and alarm update sequencing with running CRC and output register
module mbrtu_back import mbrtu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] dev_addr,
  input  logic       cmd_valid,
  input  mbrtu_cmd_t cmd,
  output logic       cmd_pop,
  mbrtu_out_if.source out_ch
);

`include "modbus_rtu_slave_frame_handler_top_macros.svh"

  logic [FIDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_alarm_r, out_alarm_nxt;
  logic              load;
  logic [7:0]        reply_byte;
  logic [15:0]       crc_base;

  assign load     = cmd_valid && (!out_valid_r || out_ch.ready);
  assign crc_base = (idx_r == '0) ? CRC_INIT : crc_r;

  always_comb begin
    case (idx_r)
      3'd0:    reply_byte = dev_addr;
      3'd1:    reply_byte = FC_READ;
      3'd2:    reply_byte = BYTE_COUNT;
      3'd3:    reply_byte = SENSOR_TYPE;
      3'd4:    reply_byte = cmd.pressure[15:8];
      3'd5:    reply_byte = cmd.pressure[7:0];
      3'd6:    reply_byte = crc_r[7:0];
      default: reply_byte = crc_r[15:8];
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_alarm_nxt = out_alarm_r;
    cmd_pop       = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (cmd.is_alarm) begin
        out_kind_nxt  = 1'b1;
        out_byte_nxt  = 8'h00;
        out_last_nxt  = 1'b1;
        out_alarm_nxt = cmd.alarm_on;
        cmd_pop       = 1'b1;
      end else begin
        out_kind_nxt  = 1'b0;
        out_byte_nxt  = reply_byte;
        out_last_nxt  = (idx_r == FIDX_W'(FRAME_LEN - 1));
        out_alarm_nxt = 1'b0;
        cmd_pop       = (idx_r == FIDX_W'(FRAME_LEN - 1));
        if (idx_r < FIDX_W'(CRC_LEN)) begin
          crc_nxt = crc16_upd(crc_base, reply_byte);
        end
        idx_nxt = idx_r + FIDX_W'(1);   // wraps to zero after the last byte
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r       <= crc_nxt;
    out_kind_r  <= out_kind_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_alarm_r <= out_alarm_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.tx_byte  = out_byte_r;
  assign out_ch.last     = out_last_r;
  assign out_ch.alarm_on = out_alarm_r;

  // a reply in progress always has its read command at the queue head
  `MBRTU_ASSERT_NOW(a_mid_reply_cmd, idx_r != '0, cmd_valid && !cmd.is_alarm, "reply lost its command")
  // retiring a command always presents a final result next
  `MBRTU_ASSERT_NEXT(a_pop_last, cmd_pop, out_valid_r && out_last_r, "pop without last result")
  // an alarm update is always a single, final result
  `MBRTU_ASSERT_NOW(a_alarm_last, out_valid_r && out_kind_r, out_last_r && (out_byte_r == 8'h00), "bad alarm result")

endmodule

// ===== rtl/modbus_rtu_slave_frame_handler_top.sv =====
// Modbus RTU slave frame handler: top level with configuration registers
//
// in_ch carries one item per transaction: a received bus byte (action 0) or
// one tick of the inter-frame gap timer (action 1). out_ch carries results:
// reply bytes to transmit (kind 0) or alarm lamp updates (kind 1); last marks
// the final result caused by one input item.
// The input side takes one item per cycle while the command queue is not
// full. A tick that ends a valid frame queues a command, which the reply
// sequencer turns into results in its output register. A read reply is
// eight results at one per cycle unless out_ch stalls, an alarm one.
// Request CRC is built as bytes arrive, reply CRC as each byte leaves.
// A two-entry command queue parts the decode from the reply sequencer:
// in_ch.ready falls only while two commands are waiting, e.g. when the
// receiver stalls out_ch during replies. A stalled result holds its value.
// Reset (rst_n, synchronous) empties the frame, stops the gap timer, clears
// the queue and output, and sets device_address to 1 and gap_ticks to 3686.
// APB registers: 0x0 device_address[7:0], 0x4 gap_ticks[15:0]; the user makes
// writes only while the block is idle, which the block does not enforce.
module modbus_rtu_slave_frame_handler_top import mbrtu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mbrtu_in_if.sink    in_ch,
  mbrtu_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  dev_addr_r, dev_addr_nxt;
  logic [15:0] gap_r, gap_nxt;
  logic        cfg_wr;
  logic        cmd_push;
  logic        cmd_pop;
  logic        cmd_full;
  logic        cmd_valid;
  mbrtu_cmd_t  cmd_in;
  mbrtu_cmd_t  cmd_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    dev_addr_nxt = dev_addr_r;
    gap_nxt      = gap_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_IDX_ADDR: dev_addr_nxt = pwdata[7:0];
        REG_IDX_GAP:  gap_nxt      = pwdata[15:0];
        default:      dev_addr_nxt = dev_addr_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IDX_ADDR: prdata = {24'h0, dev_addr_r};
      REG_IDX_GAP:  prdata = {16'h0, gap_r};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= ADDR_RST;
      gap_r      <= GAP_RST;
    end else begin
      dev_addr_r <= dev_addr_nxt;
      gap_r      <= gap_nxt;
    end
  end

  mbrtu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .dev_addr  (dev_addr_r),
    .gap_ticks (gap_r),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in)
  );

  mbrtu_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .pop       (cmd_pop),
    .full      (cmd_full),
    .not_empty (cmd_valid),
    .head      (cmd_head)
  );

  mbrtu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dev_addr  (dev_addr_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== dv/modbus_rtu_slave_frame_handler_top_test.sv =====
// Self-checking testbench for the Modbus RTU slave frame handler top level
module modbus_rtu_slave_frame_handler_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrtu_pkg::*;

  localparam int       WATCHDOG_LIMIT = 1000;
  localparam int       DRAIN_CYCLES   = 8;
  localparam int       RANDOM_ITEMS   = 260;
  localparam bit [2:0] REG_DEV_ADDR   = {REG_IDX_ADDR, 2'b00};
  localparam bit [2:0] REG_GAP_TICKS  = {REG_IDX_GAP, 2'b00};

  typedef enum bit {ACT_BYTE = 1'b0, ACT_TICK = 1'b1} action_e;
  typedef enum bit {KIND_REPLY = 1'b0, KIND_ALARM = 1'b1} kind_e;
  typedef enum int {
    FR_READ, FR_ALARM, FR_ODD, FR_FOREIGN, FR_BADCRC, FR_RAGGED, FR_OVERFLOW
  } frame_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       last;
    logic       alarm_on;
  } result_t;

  // Tracks the slave's frame state and the replies and alarm updates it owes
  class frame_scoreboard;
    bit [7:0]    rx_buf[BUFFER_DEPTH];
    int unsigned rx_len;
    bit          overflowed;
    bit [15:0]   idle_ticks;
    bit          timer_on;
    bit [7:0]    slave_addr;
    bit [15:0]   gap_limit;
    result_t     expected_q[$];
    int          errors;

    function new();
      rx_len     = 0;
      overflowed = 1'b0;
      idle_ticks = 16'h0000;
      timer_on   = 1'b0;
      slave_addr = ADDR_RST;
      gap_limit  = GAP_RST;
      errors     = 0;
    endfunction

    // Modbus CRC-16 over the first six bytes of a frame
    static function bit [15:0] crc_of(bit [7:0] msg[8]);
      bit [15:0] c;
      c = CRC_INIT;
      for (int i = 0; i < CRC_LEN; i++) begin
        c = c ^ {8'h00, msg[i]};
        for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function void write_reg(bit [2:0] addr, bit [31:0] data);
      if (addr == REG_DEV_ADDR) slave_addr = data[7:0];
      else if (addr == REG_GAP_TICKS) gap_limit = data[15:0];
    endfunction

    function void push_result(kind_e k, bit [7:0] b, bit l, bit a);
      result_t r;
      r.kind     = k;
      r.tx_byte  = b;
      r.last     = l;
      r.alarm_on = a;
      expected_q.push_back(r);
    endfunction

    function void decode_frame(bit [15:0] press);
      bit [7:0]  msg[8];
      bit [15:0] c;
      if (rx_len != FRAME_LEN || rx_buf[0] != slave_addr) return;
      for (int i = 0; i < FRAME_LEN; i++) msg[i] = rx_buf[i];
      c = crc_of(msg);
      if (msg[6] != c[7:0] || msg[7] != c[15:8]) return;
      if (msg[1] == FC_READ && msg[2] == 8'h00 && msg[3] == 8'h00 && msg[4] == 8'h00 &&
          msg[5] == READ_COUNT) begin
        msg = '{slave_addr, FC_READ, BYTE_COUNT, SENSOR_TYPE, press[15:8], press[7:0],
                8'h00, 8'h00};
        c = crc_of(msg);
        msg[6] = c[7:0];
        msg[7] = c[15:8];
        for (int k = 0; k < FRAME_LEN; k++)
          push_result(KIND_REPLY, msg[k], k == FRAME_LEN - 1, 1'b0);
      end else if (msg[1] == FC_WRITE && msg[2] == 8'h00 && msg[3] == REG_ALARM &&
                   msg[4] == 8'h00) begin
        push_result(KIND_ALARM, 8'h00, 1'b1, msg[5] != 8'h00);
      end
    endfunction

    // called for every accepted input transaction
    function void note_item(action_e act, bit [7:0] b, bit [15:0] press);
      if (act == ACT_BYTE) begin
        if (rx_len < BUFFER_DEPTH) begin
          rx_buf[rx_len] = b;
          rx_len++;
        end else begin
          overflowed = 1'b1;
        end
        idle_ticks = 16'h0000;
        timer_on   = 1'b1;
        return;
      end
      if (!timer_on) return;
      if (idle_ticks != 16'hFFFF) idle_ticks++;
      if (idle_ticks >= gap_limit && rx_len != 0) begin
        timer_on   = 1'b0;
        idle_ticks = 16'h0000;
        if (!overflowed) decode_frame(press);
        rx_len     = 0;
        overflowed = 1'b0;
      end
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d tx_byte %0h last %0d alarm_on %0d",
                 $time, got.kind, got.tx_byte, got.last, got.alarm_on);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("kind", 8'(want.kind), 8'(got.kind));
      check_field("tx_byte", want.tx_byte, got.tx_byte);
      check_field("last", 8'(want.last), 8'(got.last));
      check_field("alarm_on", 8'(want.alarm_on), 8'(got.alarm_on));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mbrtu_in_if  in_ch();
  mbrtu_out_if out_ch();

  frame_scoreboard sb = new();
  bit              calm;
  int              items_sent;
  int              quiet_cycles = 0;

  modbus_rtu_slave_frame_handler_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** modbus_rtu_slave_frame_handler_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.kind, out_ch.tx_byte, out_ch.last, out_ch.alarm_on};
      sb.check_result(got);
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit [15:0] pick_pressure(int press);
    int r;
    if (press >= 0) return press[15:0];
    r = $urandom_range(0, 15);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic frame_e pick_frame();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return FR_READ;
    if (r < 55) return FR_ALARM;
    if (r < 65) return FR_ODD;
    if (r < 72) return FR_FOREIGN;
    if (r < 80) return FR_BADCRC;
    if (r < 92) return FR_RAGGED;
    return FR_OVERFLOW;
  endfunction

  initial begin : sink_pacer
    int run;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      run = $urandom_range(1, 24);
      repeat (run) @(posedge clk);
      stall = calm ? 0 : pick_gap();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic send_item(action_e act, bit [7:0] b, bit [15:0] press);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.rx_byte  <= b;
    in_ch.pressure <= press;
    do @(posedge clk); while (!in_ch.ready);
    // ticks with the timer stopped are not counted
    if (act == ACT_BYTE || sb.timer_on) items_sent++;
    sb.note_item(act, b, press);
  endtask

  task automatic send_tick(int press = -1);
    send_item(ACT_TICK, 8'($urandom_range(0, 255)), pick_pressure(press));
  endtask

  task automatic send_frame(frame_e sel, int press = -1, int wval = -1);
    bit [7:0]  msg[8];
    bit [7:0]  seq[$];
    bit [15:0] c;
    int        n;
    msg = '{sb.slave_addr, FC_READ, 8'h00, 8'h00, 8'h00, READ_COUNT, 8'h00, 8'h00};
    if (sel == FR_ALARM || (sel != FR_READ && $urandom_range(0, 1) == 1)) begin
      msg[1] = FC_WRITE;
      msg[3] = REG_ALARM;
      if (wval >= 0) msg[5] = wval[7:0];
      else msg[5] = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    end
    if (sel == FR_ODD) begin
      n = $urandom_range(1, 5);
      msg[n] = msg[n] ^ 8'($urandom_range(1, 255));
    end
    if (sel == FR_FOREIGN) msg[0] = msg[0] ^ 8'($urandom_range(1, 255));
    c = frame_scoreboard::crc_of(msg);
    msg[6] = c[7:0];
    msg[7] = c[15:8];
    if (sel == FR_BADCRC) begin
      n = $urandom_range(6, 7);
      msg[n] = msg[n] ^ 8'($urandom_range(1, 255));
    end
    foreach (msg[i]) seq.push_back(msg[i]);
    if (sel == FR_RAGGED || sel == FR_OVERFLOW) begin
      if (sel == FR_OVERFLOW) n = $urandom_range(BUFFER_DEPTH + 1, BUFFER_DEPTH + 4);
      else if ($urandom_range(0, 1) == 1) n = $urandom_range(1, FRAME_LEN - 1);
      else n = $urandom_range(FRAME_LEN + 1, BUFFER_DEPTH);
      if (sel == FR_RAGGED && $urandom_range(0, 3) == 0) begin
        // pure noise of 1 to BUFFER_DEPTH bytes now and then
        n = $urandom_range(1, BUFFER_DEPTH);
        foreach (seq[i]) seq[i] = 8'($urandom_range(0, 255));
      end
      while (seq.size() > n) void'(seq.pop_back());
      while (seq.size() < n) seq.push_back(8'($urandom_range(0, 255)));
    end
    foreach (seq[i]) begin
      send_item(ACT_BYTE, seq[i], pick_pressure(press));
      // ticks short of the gap inside a frame must not end it
      if (i < seq.size() - 1 && sb.gap_limit > 1 && sb.gap_limit <= 16 &&
          $urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, sb.gap_limit - 1)) send_tick(press);
    end
    while (sb.timer_on) send_tick(press);
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) send_tick(press);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(bit wr, bit [2:0] addr, bit [31:0] wdata, output bit [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_reg(bit [2:0] addr, bit [31:0] data);
    bit [31:0] rd;
    bit [31:0] mask;
    apb_xfer(1'b1, addr, data, rd);
    sb.write_reg(addr, data);
    apb_xfer(1'b0, addr, 32'h0, rd);
    mask = (addr == REG_GAP_TICKS) ? 32'h0000_FFFF : 32'h0000_00FF;
    if ((rd & mask) !== (data & mask)) begin
      $display("%0t: readback of register %0h, expected %0h, actual %0h",
               $time, addr, data & mask, rd);
      sb.errors++;
    end
  endtask

  task automatic apply_cfg(bit [7:0] dev_addr, bit [15:0] gap);
    settle();
    set_reg(REG_DEV_ADDR, {24'h0, dev_addr});
    set_reg(REG_GAP_TICKS, {16'h0, gap});
  endtask

  initial begin : stimulus
    int        base;
    int        phase;
    bit [31:0] rd;
    rst_n          <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= 3'h0;
    pwdata         <= 32'h0;
    in_ch.valid    <= 1'b0;
    in_ch.action   <= ACT_BYTE;
    in_ch.rx_byte  <= 8'h00;
    in_ch.pressure <= 16'h0000;
    items_sent = 0;
    calm       = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: gap of 3686 ticks read back, address 1 answered
    apb_xfer(1'b0, REG_GAP_TICKS, 32'h0, rd);
    if (rd[15:0] !== GAP_RST) begin
      $display("%0t: reset value of gap_ticks, expected %0h, actual %0h",
               $time, GAP_RST, rd[15:0]);
      sb.errors++;
    end
    set_reg(REG_GAP_TICKS, 32'd2);
    send_frame(FR_READ);

    apply_cfg(8'h00, 16'd1);
    calm = 1'b0;
    // timer stopped, so these ticks are dropped
    send_tick(16'h0000);
    send_tick(16'hFFFF);
    send_frame(FR_READ, 16'hFFFF);
    send_frame(FR_ALARM, -1, 8'hFF);
    send_frame(FR_ALARM, 16'h0000, 8'h00);

    // widest register values read back
    apply_cfg(8'hFF, 16'hFFFF);
    calm = 1'b1;

    base  = items_sent;
    phase = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin
          apply_cfg(8'($urandom_range(0, 255)), 16'd1);
          calm = 1'b0;
        end
        1: begin
          apply_cfg(8'hFF, 16'($urandom_range(2, 4)));
          calm = 1'b0;
        end
        2: begin
          apply_cfg(8'h00, 16'd2);
          calm = 1'b1;
        end
        default: begin
          apply_cfg(8'($urandom_range(0, 255)), 16'($urandom_range(5, 12)));
          calm = 1'b0;
        end
      endcase
      repeat (6) send_frame(pick_frame());
      phase++;
    end

    settle();
    if (sb.errors == 0) begin
      $display("** modbus_rtu_slave_frame_handler_top: PASSED **");
    end else begin
      $display("** modbus_rtu_slave_frame_handler_top: FAILED **");
    end
    $finish;
  end

endmodule
